// ===== src/efr_pkg.sv =====
package efr_pkg;

  localparam logic [7:0] StartMark = 8'hEB;
  localparam logic [7:0] EscMark   = 8'hDA;
  localparam logic [7:0] EscXor    = 8'h19;
  localparam logic [7:0] MinLength = 8'd4;

  localparam logic [7:0] PosHunt   = 8'd0;
  localparam logic [7:0] PosLength = 8'd1;
  localparam logic [7:0] PosCtrl   = 8'd2;

  typedef enum logic [1:0] {
    KIND_CONTROL = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_GOOD    = 2'd2,
    KIND_BAD     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] position;
    logic       escape_pending;
    logic [7:0] frame_length;
    logic [7:0] running_sum;
  } state_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
  } deframed_t;

endpackage

// ===== src/efr_step.sv =====
module efr_step import efr_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] rx_byte_i,
  output state_t     state_o,
  output logic       res_valid_o,
  output deframed_t  res_o
);

  logic [7:0] byte_w;
  logic       last_w;

  assign byte_w = state_i.escape_pending ? (rx_byte_i ^ EscXor) : rx_byte_i;
  assign last_w = ({1'b0, state_i.position} + 9'd1) >= {1'b0, state_i.frame_length};

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o.kind  = KIND_CONTROL;
    res_o.value = byte_w;
    priority if (state_i.position == PosHunt) begin
      if (rx_byte_i == StartMark) begin
        state_o.position       = PosLength;
        state_o.escape_pending = 1'b0;
        state_o.running_sum    = StartMark;
      end
    end else if (rx_byte_i == EscMark) begin
      state_o.escape_pending = 1'b1;
    end else if (state_i.position == PosLength) begin
      state_o.escape_pending = 1'b0;
      if (byte_w < MinLength) begin
        state_o.position = PosHunt;
      end else begin
        state_o.frame_length = byte_w;
        state_o.running_sum  = state_i.running_sum + byte_w;
        state_o.position     = PosCtrl;
      end
    end else if (last_w) begin
      state_o.escape_pending = 1'b0;
      state_o.position       = PosHunt;
      res_valid_o            = 1'b1;
      res_o.kind             = (byte_w == state_i.running_sum) ? KIND_GOOD : KIND_BAD;
      res_o.value            = state_i.running_sum;
    end else begin
      state_o.escape_pending = 1'b0;
      state_o.running_sum    = state_i.running_sum + byte_w;
      state_o.position       = state_i.position + 8'd1;
      res_valid_o            = 1'b1;
      res_o.kind             = (state_i.position == PosCtrl) ? KIND_CONTROL : KIND_PAYLOAD;
    end
  end

endmodule

// ===== src/escaped_frame_receiver_core.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    rx_byte_i[7:0]
// output    out        out_valid_o / out_ready_i  kind_o[1:0], value_o[7:0]
//
// A byte that yields a result presents it on the output register in the cycle
// after acceptance.
// One input transaction can be accepted every cycle while the output register
// is empty or its transaction is taken in the same cycle.
// Reset returns the deframer to hunting for the start marker and empties the output.
// An output stall holds in_ready_o low until the pending result is taken.
module escaped_frame_receiver_core import efr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_o
);

  state_t    state_q, state_d;
  deframed_t res_q, res_w;
  logic      res_valid_w;
  logic      out_valid_q, out_valid_d;
  logic      in_fire;

  efr_step u_step (
    .state_i     (state_q),
    .rx_byte_i   (rx_byte_i),
    .state_o     (state_d),
    .res_valid_o (res_valid_w),
    .res_o       (res_w)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (in_fire && res_valid_w) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid_w) begin
      res_q <= res_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign value_o     = res_q.value;

`ifndef ASSERT_OFF
  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.position >= PosCtrl) |-> (state_q.frame_length >= MinLength))
    else $error("frame length below minimum inside a frame");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.position >= PosCtrl) |-> (state_q.position < state_q.frame_length))
    else $error("position ran past frame length");

  a_esc_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.position == PosHunt) |-> !state_q.escape_pending)
    else $error("escape pending while hunting");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_fire)
    else $error("input accepted while result stalled");
`endif

endmodule
